/* hw/rtl/dctok_pkg.sv */
// ----------------------------------------------------------------------------
// dctok_pkg
// Shared types and token codes of the command line tokenizer.
// ----------------------------------------------------------------------------
package dctok_pkg;

  localparam logic [2:0] TokCmdByte = 3'd0;
  localparam logic [2:0] TokCmdEnd  = 3'd1;
  localparam logic [2:0] TokKey     = 3'd2;
  localparam logic [2:0] TokValByte = 3'd3;
  localparam logic [2:0] TokValEnd  = 3'd4;
  localparam logic [2:0] TokError   = 3'd5;
  localparam logic [2:0] TokLineEnd = 3'd6;

  localparam logic ErrParse = 1'b0;
  localparam logic ErrDupKey = 1'b1;

  // result queue geometry
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoAw    = 2;

  typedef struct packed {
    logic [2:0] token_kind;
    logic [7:0] token_byte;
    logic       error_kind;
    logic       run_last;
  } tok_t;

  // results produced by one accepted request
  typedef struct packed {
    logic [1:0]     n;
    tok_t [1:0]     tok;
  } push_t;

endpackage

/* hw/rtl/dctok_if.sv */
// ----------------------------------------------------------------------------
// dctok_in_if / dctok_out_if
// Valid/ready channels for input bytes and result tokens.
// ----------------------------------------------------------------------------
interface dctok_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

interface dctok_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] token_kind;
  logic [7:0] token_byte;
  logic       error_kind;
  logic       run_last;

  modport source (output valid, output token_kind, output token_byte,
                  output error_kind, output run_last, input ready);
  modport sink (input valid, input token_kind, input token_byte,
                input error_kind, input run_last, output ready);
endinterface

/* hw/rtl/dctok_parser.sv */
// ----------------------------------------------------------------------------
// dctok_parser
// Per-byte parse state and token generation; up to two tokens per request.
// ----------------------------------------------------------------------------
module dctok_parser (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_fire_i,
  input  logic [7:0]         in_byte_i,
  output dctok_pkg::push_t   push_o
);

  localparam logic [2:0] MCmd    = 3'd0;
  localparam logic [2:0] MNormal = 3'd1;
  localparam logic [2:0] MOpt    = 3'd2;
  localparam logic [2:0] MSep    = 3'd3;
  localparam logic [2:0] MFirst  = 3'd4;
  localparam logic [2:0] MValue  = 3'd5;
  localparam logic [2:0] MQuoted = 3'd6;
  localparam logic [2:0] MSkip   = 3'd7;

  localparam logic [1:0] EscNone  = 2'd0;
  localparam logic [1:0] EscSlash = 2'd1;
  localparam logic [1:0] EscHex   = 2'd2;
  localparam logic [1:0] EscOct   = 2'd3;

  localparam logic [7:0] ChNul   = 8'h00;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChQuote = 8'h22;
  localparam logic [7:0] ChDash  = 8'h2D;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChSeven = 8'h37;
  localparam logic [7:0] ChLa    = 8'h61;
  localparam logic [7:0] ChLb    = 8'h62;
  localparam logic [7:0] ChLf    = 8'h66;
  localparam logic [7:0] ChLn    = 8'h6E;
  localparam logic [7:0] ChLr    = 8'h72;
  localparam logic [7:0] ChLt    = 8'h74;
  localparam logic [7:0] ChLv    = 8'h76;
  localparam logic [7:0] ChLx    = 8'h78;

  // {valid, digit}
  function automatic logic [4:0] hex_digit(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b inside {[8'h30:8'h39]}) begin
      r = {1'b1, 4'(b - 8'h30)};
    end else if (b inside {[8'h61:8'h66]}) begin
      r = {1'b1, 4'(b - 8'h57)};
    end else if (b inside {[8'h41:8'h46]}) begin
      r = {1'b1, 4'(b - 8'h37)};
    end
    return r;
  endfunction

  function automatic dctok_pkg::tok_t mk_tok(input logic [2:0] kind, input logic [7:0] b,
                                             input logic ek);
    dctok_pkg::tok_t t;
    t.token_kind = kind;
    t.token_byte = b;
    t.error_kind = ek;
    t.run_last   = 1'b0;
    return t;
  endfunction

  logic [2:0]   mode_q, mode_d;
  logic [7:0]   key_q, key_d;
  logic [1:0]   esc_q, esc_d;
  logic [1:0]   cnt_q, cnt_d;
  logic [8:0]   acc_q, acc_d;
  logic         failed_q, failed_d;
  logic         first_q, first_d;
  logic [255:0] seen_q, seen_d;

  logic         do_plain, do_fin, le;
  logic [2:0]   fin_mode;
  logic [1:0]   n;
  logic [8:0]   acc_n;
  logic [1:0]   cnt_n;
  logic [4:0]   hx;
  dctok_pkg::tok_t [1:0] res;

  always_comb begin
    mode_d   = mode_q;
    key_d    = key_q;
    esc_d    = esc_q;
    cnt_d    = cnt_q;
    acc_d    = acc_q;
    failed_d = failed_q;
    first_d  = 1'b0;
    seen_d   = first_q ? '0 : seen_q;
    do_plain = 1'b0;
    do_fin   = 1'b0;
    le       = 1'b0;
    fin_mode = mode_q;
    n        = 2'd0;
    res      = '0;
    acc_n    = 9'd0;
    cnt_n    = 2'd0;
    hx       = hex_digit(in_byte_i);

    if (failed_q) begin
      le = (in_byte_i == ChNul);
    end else begin
      case (mode_q)
        MCmd: begin
          if (in_byte_i == ChNul) begin
            if (first_q) begin
              res[n[0]] = mk_tok(dctok_pkg::TokError, ChNul, dctok_pkg::ErrParse);
            end else begin
              res[n[0]] = mk_tok(dctok_pkg::TokCmdEnd, ChNul, 1'b0);
            end
            n  = n + 2'd1;
            le = 1'b1;
          end else if (in_byte_i == ChSpace) begin
            res[n[0]] = mk_tok(dctok_pkg::TokCmdEnd, ChNul, 1'b0);
            n = n + 2'd1;
            mode_d = MNormal;
          end else begin
            res[n[0]] = mk_tok(dctok_pkg::TokCmdByte, in_byte_i, 1'b0);
            n = n + 2'd1;
          end
        end
        MNormal, MSep: begin
          if (mode_q == MNormal && in_byte_i == ChDash) begin
            mode_d = MOpt;
          end else if (mode_q == MSep && in_byte_i == ChSpace) begin
            mode_d = MFirst;
          end else begin
            res[n[0]] = mk_tok(dctok_pkg::TokError, ChNul, dctok_pkg::ErrParse);
            n = n + 2'd1;
            failed_d = 1'b1;
            le = (in_byte_i == ChNul);
          end
        end
        MOpt: begin
          if (in_byte_i == ChNul) begin
            le = 1'b1;
          end else begin
            key_d = in_byte_i;
            res[n[0]] = mk_tok(dctok_pkg::TokKey, in_byte_i, 1'b0);
            n = n + 2'd1;
            mode_d = MSep;
          end
        end
        MFirst: begin
          if (in_byte_i == ChNul) begin
            le = 1'b1;
          end else if (in_byte_i == ChQuote && key_q != ChDash) begin
            mode_d = MQuoted;
            esc_d  = EscNone;
            cnt_d  = 2'd0;
            acc_d  = 9'd0;
          end else begin
            res[n[0]] = mk_tok(dctok_pkg::TokValByte, in_byte_i, 1'b0);
            n = n + 2'd1;
            mode_d = MValue;
          end
        end
        MValue: begin
          if (in_byte_i == ChNul) begin
            do_fin = 1'b1;
            le     = 1'b1;
          end else if (in_byte_i == ChSpace && key_q != ChDash) begin
            do_fin   = 1'b1;
            fin_mode = MNormal;
          end else begin
            res[n[0]] = mk_tok(dctok_pkg::TokValByte, in_byte_i, 1'b0);
            n = n + 2'd1;
          end
        end
        MQuoted: begin
          case (esc_q)
            EscSlash: begin
              esc_d = EscNone;
              case (in_byte_i)
                ChNul: le = 1'b1;
                ChLn: begin res[n[0]] = mk_tok(dctok_pkg::TokValByte, 8'd10, 1'b0); n = n + 2'd1; end
                ChLt: begin res[n[0]] = mk_tok(dctok_pkg::TokValByte, 8'd9, 1'b0); n = n + 2'd1; end
                ChLr: begin res[n[0]] = mk_tok(dctok_pkg::TokValByte, 8'd13, 1'b0); n = n + 2'd1; end
                ChLa: begin res[n[0]] = mk_tok(dctok_pkg::TokValByte, 8'd7, 1'b0); n = n + 2'd1; end
                ChLv: begin res[n[0]] = mk_tok(dctok_pkg::TokValByte, 8'd11, 1'b0); n = n + 2'd1; end
                ChLb: begin res[n[0]] = mk_tok(dctok_pkg::TokValByte, 8'd8, 1'b0); n = n + 2'd1; end
                ChLf: begin res[n[0]] = mk_tok(dctok_pkg::TokValByte, 8'd12, 1'b0); n = n + 2'd1; end
                ChLx: begin
                  esc_d = EscHex;
                  cnt_d = 2'd0;
                  acc_d = 9'd0;
                end
                default: begin
                  if (in_byte_i inside {[ChZero:ChSeven]}) begin
                    esc_d = EscOct;
                    cnt_d = 2'd1;
                    acc_d = {6'd0, in_byte_i[2:0]};
                  end else begin
                    res[n[0]] = mk_tok(dctok_pkg::TokValByte, in_byte_i, 1'b0);
                    n = n + 2'd1;
                  end
                end
              endcase
            end
            EscHex: begin
              if (hx[4]) begin
                acc_n = {acc_q[4:0], hx[3:0]};
                cnt_n = cnt_q + 2'd1;
                acc_d = acc_n;
                cnt_d = cnt_n;
                if (cnt_n >= 2'd2) begin
                  res[n[0]] = mk_tok(dctok_pkg::TokValByte, acc_n[7:0], 1'b0);
                  n = n + 2'd1;
                  esc_d = EscNone;
                  cnt_d = 2'd0;
                end
              end else begin
                res[n[0]] = mk_tok(dctok_pkg::TokValByte,
                                   (cnt_q == 2'd0) ? ChLx : acc_q[7:0], 1'b0);
                n = n + 2'd1;
                cnt_d = 2'd0;
                do_plain = 1'b1;
              end
            end
            EscOct: begin
              if (in_byte_i inside {[ChZero:ChSeven]}) begin
                acc_n = {acc_q[5:0], in_byte_i[2:0]};
                cnt_n = cnt_q + 2'd1;
                acc_d = acc_n;
                cnt_d = cnt_n;
                if (cnt_n >= 2'd3) begin
                  res[n[0]] = mk_tok(dctok_pkg::TokValByte, acc_n[7:0], 1'b0);
                  n = n + 2'd1;
                  esc_d = EscNone;
                  cnt_d = 2'd0;
                end
              end else begin
                res[n[0]] = mk_tok(dctok_pkg::TokValByte, acc_q[7:0], 1'b0);
                n = n + 2'd1;
                cnt_d = 2'd0;
                do_plain = 1'b1;
              end
            end
            default: do_plain = 1'b1;
          endcase
        end
        default: begin
          // byte after the closing quote
          if (in_byte_i == ChNul) begin
            le = 1'b1;
          end else begin
            mode_d = MNormal;
          end
        end
      endcase
    end

    if (do_plain) begin
      esc_d = EscNone;
      if (in_byte_i == ChNul) begin
        le = 1'b1;
      end else if (in_byte_i == ChBslash) begin
        esc_d = EscSlash;
      end else if (in_byte_i == ChQuote) begin
        do_fin   = 1'b1;
        fin_mode = MSkip;
      end else begin
        res[n[0]] = mk_tok(dctok_pkg::TokValByte, in_byte_i, 1'b0);
        n = n + 2'd1;
      end
    end

    if (do_fin) begin
      if (seen_d[key_q]) begin
        res[n[0]] = mk_tok(dctok_pkg::TokError, ChNul, dctok_pkg::ErrDupKey);
        n = n + 2'd1;
        failed_d = 1'b1;
      end else begin
        seen_d[key_q] = 1'b1;
        res[n[0]] = mk_tok(dctok_pkg::TokValEnd, ChNul, 1'b0);
        n = n + 2'd1;
        mode_d = fin_mode;
      end
    end

    if (le) begin
      res[n[0]] = mk_tok(dctok_pkg::TokLineEnd, ChNul, 1'b0);
      n = n + 2'd1;
      mode_d   = MCmd;
      key_d    = ChNul;
      esc_d    = EscNone;
      cnt_d    = 2'd0;
      acc_d    = 9'd0;
      failed_d = 1'b0;
      first_d  = 1'b1;
    end

    if (n == 2'd2) begin
      res[1].run_last = 1'b1;
    end else if (n == 2'd1) begin
      res[0].run_last = 1'b1;
    end

    push_o.n   = in_fire_i ? n : 2'd0;
    push_o.tok = res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MCmd;
      key_q    <= ChNul;
      esc_q    <= EscNone;
      cnt_q    <= 2'd0;
      acc_q    <= 9'd0;
      failed_q <= 1'b0;
      first_q  <= 1'b1;
      seen_q   <= '0;
    end else if (in_fire_i) begin
      mode_q   <= mode_d;
      key_q    <= key_d;
      esc_q    <= esc_d;
      cnt_q    <= cnt_d;
      acc_q    <= acc_d;
      failed_q <= failed_d;
      first_q  <= first_d;
      seen_q   <= seen_d;
    end
  end

  a_two_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o.n == 2'd2 |-> !push_o.tok[0].run_last && push_o.tok[1].run_last)
    else $error("run_last misplaced on a two-token request");

  a_failed_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire_i && failed_q && push_o.n != 2'd0 |->
      push_o.n == 2'd1 && push_o.tok[0].token_kind == dctok_pkg::TokLineEnd)
    else $error("token other than line end on a failed line");

  a_nul_ends_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire_i && in_byte_i == ChNul |=> first_q && !failed_q && mode_q == MCmd)
    else $error("zero byte did not end the line");

endmodule

/* hw/rtl/dctok_fifo.sv */
// ----------------------------------------------------------------------------
// dctok_fifo
// Result queue: takes up to two tokens per cycle, delivers one per cycle.
// ----------------------------------------------------------------------------
module dctok_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dctok_pkg::push_t   push_i,
  input  logic               pop_i,
  output logic               room_o,
  output logic               valid_o,
  output dctok_pkg::tok_t    head_o
);

  localparam int unsigned FifoCw = dctok_pkg::FifoAw + 1;
  localparam logic [FifoCw-1:0] DepthC = FifoCw'(dctok_pkg::FifoDepth);

  dctok_pkg::tok_t mem_q [dctok_pkg::FifoDepth];
  logic [dctok_pkg::FifoAw-1:0] wr_ptr_q, rd_ptr_q, wr_ptr_1;
  logic [FifoCw-1:0]            count_q;
  logic                         do_pop;

  assign do_pop   = pop_i && valid_o;
  assign wr_ptr_1 = wr_ptr_q + 1'b1;
  assign valid_o  = (count_q != '0);
  assign head_o   = mem_q[rd_ptr_q];
  assign room_o   = (count_q <= DepthC - FifoCw'(2));

  always_ff @(posedge clk_i) begin
    if (push_i.n != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.tok[0];
    end
    if (push_i.n == 2'd2) begin
      mem_q[wr_ptr_1] <= push_i.tok[1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + dctok_pkg::FifoAw'(push_i.n);
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      count_q <= count_q + FifoCw'(push_i.n) - FifoCw'(do_pop);
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= DepthC)
    else $error("result queue count out of range");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.n != 2'd0 |-> (count_q + FifoCw'(push_i.n)) <= DepthC)
    else $error("result queue overflow");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.n != 2'd0 |-> room_o)
    else $error("push without room");

endmodule

/* hw/rtl/debug_command_line_tokenizer_unit.sv */
// ----------------------------------------------------------------------------
// debug_command_line_tokenizer_unit
// Debugger command line tokenizer: bytes in, tagged tokens out.
// ----------------------------------------------------------------------------
// in_i carries one line byte per request; a zero byte ends the line. out_o
// carries tokens: command bytes, command end, option key, value bytes, value
// end, error and line end. Each byte yields zero, one or two tokens; run_last
// marks the last token of a byte.
// A byte is taken in any cycle it is offered while the queue has room; its
// tokens are in a four-entry result queue the next cycle. One byte per cycle
// is sustained while the queue has room for two tokens; output is limited to
// one token per cycle by the queue read port, so a byte that gives two tokens
// needs two pops to leave the queue.
// When the receiver stalls, the queue fills and in_i.ready drops once fewer
// than two entries are free. Reset empties the queue and puts the parser at
// the start of a line with the seen-key set clear.
// ----------------------------------------------------------------------------
module debug_command_line_tokenizer_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  dctok_in_if.sink    in_i,
  dctok_out_if.source out_o
);

  dctok_pkg::push_t push;
  dctok_pkg::tok_t  head;
  logic             room;
  logic             in_fire;

  assign in_i.ready = room;
  assign in_fire    = in_i.valid && room;

  dctok_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_fire_i (in_fire),
    .in_byte_i (in_i.in_byte),
    .push_o    (push)
  );

  dctok_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (out_o.ready),
    .room_o  (room),
    .valid_o (out_o.valid),
    .head_o  (head)
  );

  assign out_o.token_kind = head.token_kind;
  assign out_o.token_byte = head.token_byte;
  assign out_o.error_kind = head.error_kind;
  assign out_o.run_last   = head.run_last;

endmodule

/* tb/dctok_token_checker.sv */
// ----------------------------------------------------------------------------
// dctok_token_checker
// Watches both channels of the command line tokenizer and checks its tokens.
// Every accepted request byte runs through a local parser model that queues
// the tokens it should cause; every accepted token is compared field by field
// with the oldest queued one. Reports a mismatch count and the queue depth.
// ----------------------------------------------------------------------------
module dctok_token_checker (
  input  logic  clk_i,
  input  logic  rst_ni,
  dctok_in_if   in_i,
  dctok_out_if  tok_i,
  output int    fail_count_o,
  output int    pending_o
);

  typedef enum logic [2:0] {
    PmCmd, PmNormal, PmOpt, PmSep, PmFirst, PmValue, PmQuoted, PmSkip
  } parse_mode_e;

  typedef enum logic [1:0] {EscNone, EscSlash, EscHex, EscOct} esc_phase_e;

  localparam logic [7:0] ChNul    = 8'h00;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChDash   = 8'h2D;
  localparam logic [7:0] ChQuote  = 8'h22;
  localparam logic [7:0] ChBslash = 8'h5C;

  parse_mode_e  mode;
  esc_phase_e   esc;
  logic [7:0]   cur_key;
  logic [1:0]   esc_digits;
  logic [8:0]   esc_acc;
  logic         line_failed;
  logic         line_start;
  logic [255:0] seen_keys;

  dctok_pkg::tok_t step_toks [2];
  int              step_n;
  dctok_pkg::tok_t expected_tokens [$];
  int              mismatches;

  function automatic void reset_parser();
    mode        = PmCmd;
    esc         = EscNone;
    cur_key     = '0;
    esc_digits  = '0;
    esc_acc     = '0;
    line_failed = 1'b0;
    line_start  = 1'b1;
    seen_keys   = '0;
  endfunction

  function automatic void add_token(input logic [2:0] kind, input logic [7:0] val,
                                    input logic ek);
    if (step_n < 2) begin
      step_toks[step_n] = '{token_kind: kind, token_byte: val, error_kind: ek,
                            run_last: 1'b0};
      step_n++;
    end
  endfunction

  function automatic void end_line();
    add_token(dctok_pkg::TokLineEnd, 8'h00, 1'b0);
    mode        = PmCmd;
    cur_key     = '0;
    esc         = EscNone;
    esc_digits  = '0;
    esc_acc     = '0;
    line_failed = 1'b0;
    line_start  = 1'b1;
  endfunction

  function automatic void flag_error(input logic ek);
    add_token(dctok_pkg::TokError, 8'h00, ek);
    line_failed = 1'b1;
  endfunction

  // value end, or duplicate key error in its place
  function automatic bit close_value();
    if (seen_keys[cur_key]) begin
      flag_error(dctok_pkg::ErrDupKey);
      return 1'b0;
    end
    seen_keys[cur_key] = 1'b1;
    add_token(dctok_pkg::TokValEnd, 8'h00, 1'b0);
    return 1'b1;
  endfunction

  function automatic int hex_digit(input logic [7:0] b);
    if (b >= "0" && b <= "9") return int'(b - "0");
    if (b >= "a" && b <= "f") return int'(b - "a") + 10;
    if (b >= "A" && b <= "F") return int'(b - "A") + 10;
    return -1;
  endfunction

  function automatic void quoted_plain(input logic [7:0] b);
    esc = EscNone;
    if (b == ChNul) begin
      end_line();
    end else if (b == ChBslash) begin
      esc = EscSlash;
    end else if (b == ChQuote) begin
      if (close_value()) mode = PmSkip;
    end else begin
      add_token(dctok_pkg::TokValByte, b, 1'b0);
    end
  endfunction

  function automatic void quoted_byte(input logic [7:0] b);
    int h;
    case (esc)
      EscSlash: begin
        esc = EscNone;
        case (b)
          ChNul: end_line();
          "n": add_token(dctok_pkg::TokValByte, 8'd10, 1'b0);
          "t": add_token(dctok_pkg::TokValByte, 8'd9, 1'b0);
          "r": add_token(dctok_pkg::TokValByte, 8'd13, 1'b0);
          "a": add_token(dctok_pkg::TokValByte, 8'd7, 1'b0);
          "v": add_token(dctok_pkg::TokValByte, 8'd11, 1'b0);
          "b": add_token(dctok_pkg::TokValByte, 8'd8, 1'b0);
          "f": add_token(dctok_pkg::TokValByte, 8'd12, 1'b0);
          "x": begin
            esc        = EscHex;
            esc_digits = '0;
            esc_acc    = '0;
          end
          default: begin
            if (b >= "0" && b <= "7") begin
              esc        = EscOct;
              esc_digits = 2'd1;
              esc_acc    = {6'd0, b[2:0]};
            end else begin
              add_token(dctok_pkg::TokValByte, b, 1'b0);
            end
          end
        endcase
      end
      EscHex: begin
        h = hex_digit(b);
        if (h >= 0) begin
          esc_acc    = {esc_acc[4:0], h[3:0]};
          esc_digits = esc_digits + 2'd1;
          if (esc_digits >= 2'd2) begin
            add_token(dctok_pkg::TokValByte, esc_acc[7:0], 1'b0);
            esc        = EscNone;
            esc_digits = '0;
          end
        end else begin
          add_token(dctok_pkg::TokValByte,
                    (esc_digits == 2'd0) ? 8'h78 : esc_acc[7:0], 1'b0);
          esc_digits = '0;
          quoted_plain(b);
        end
      end
      EscOct: begin
        if (b >= "0" && b <= "7") begin
          esc_acc    = {esc_acc[5:0], b[2:0]};
          esc_digits = esc_digits + 2'd1;
          if (esc_digits >= 2'd3) begin
            add_token(dctok_pkg::TokValByte, esc_acc[7:0], 1'b0);
            esc        = EscNone;
            esc_digits = '0;
          end
        end else begin
          add_token(dctok_pkg::TokValByte, esc_acc[7:0], 1'b0);
          esc_digits = '0;
          quoted_plain(b);
        end
      end
      default: quoted_plain(b);
    endcase
  endfunction

  function automatic void tokenize(input logic [7:0] b);
    logic first_b;
    first_b = line_start;
    step_n  = 0;
    if (first_b) begin
      seen_keys  = '0;
      line_start = 1'b0;
    end
    if (line_failed) begin
      if (b == ChNul) end_line();
    end else begin
      case (mode)
        PmCmd: begin
          if (b == ChNul) begin
            if (first_b) flag_error(dctok_pkg::ErrParse);
            else add_token(dctok_pkg::TokCmdEnd, 8'h00, 1'b0);
            end_line();
          end else if (b == ChSpace) begin
            add_token(dctok_pkg::TokCmdEnd, 8'h00, 1'b0);
            mode = PmNormal;
          end else begin
            add_token(dctok_pkg::TokCmdByte, b, 1'b0);
          end
        end
        PmNormal: begin
          if (b == ChDash) begin
            mode = PmOpt;
          end else begin
            flag_error(dctok_pkg::ErrParse);
            if (b == ChNul) end_line();
          end
        end
        PmOpt: begin
          if (b == ChNul) begin
            end_line();
          end else begin
            cur_key = b;
            add_token(dctok_pkg::TokKey, b, 1'b0);
            mode = PmSep;
          end
        end
        PmSep: begin
          if (b == ChSpace) begin
            mode = PmFirst;
          end else begin
            flag_error(dctok_pkg::ErrParse);
            if (b == ChNul) end_line();
          end
        end
        PmFirst: begin
          if (b == ChNul) begin
            end_line();
          end else if (b == ChQuote && cur_key != ChDash) begin
            mode       = PmQuoted;
            esc        = EscNone;
            esc_digits = '0;
            esc_acc    = '0;
          end else begin
            add_token(dctok_pkg::TokValByte, b, 1'b0);
            mode = PmValue;
          end
        end
        PmValue: begin
          if (b == ChNul) begin
            void'(close_value());
            end_line();
          end else if (b == ChSpace && cur_key != ChDash) begin
            if (close_value()) mode = PmNormal;
          end else begin
            add_token(dctok_pkg::TokValByte, b, 1'b0);
          end
        end
        PmQuoted: quoted_byte(b);
        default: begin
          if (b == ChNul) end_line();
          else mode = PmNormal;
        end
      endcase
    end
    if (step_n > 0) step_toks[step_n-1].run_last = 1'b1;
    for (int i = 0; i < step_n; i++) expected_tokens.push_back(step_toks[i]);
  endfunction

  function automatic void check_token();
    dctok_pkg::tok_t want;
    if (expected_tokens.size() == 0) begin
      $display("%0t: unexpected token kind %0d byte %02h error %0d last %0d", $time,
               tok_i.token_kind, tok_i.token_byte, tok_i.error_kind, tok_i.run_last);
      mismatches++;
      return;
    end
    want = expected_tokens.pop_front();
    if (tok_i.token_kind !== want.token_kind) begin
      $display("%0t: token_kind expected %0d actual %0d", $time,
               want.token_kind, tok_i.token_kind);
      mismatches++;
    end
    if (tok_i.token_byte !== want.token_byte) begin
      $display("%0t: token_byte expected %02h actual %02h", $time,
               want.token_byte, tok_i.token_byte);
      mismatches++;
    end
    if (tok_i.error_kind !== want.error_kind) begin
      $display("%0t: error_kind expected %0d actual %0d", $time,
               want.error_kind, tok_i.error_kind);
      mismatches++;
    end
    if (tok_i.run_last !== want.run_last) begin
      $display("%0t: run_last expected %0d actual %0d", $time,
               want.run_last, tok_i.run_last);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reset_parser();
      expected_tokens.delete();
      mismatches = 0;
      fail_count_o <= 0;
      pending_o <= 0;
    end else begin
      if (in_i.valid && in_i.ready) tokenize(in_i.in_byte);
      if (tok_i.valid && tok_i.ready) check_token();
      fail_count_o <= mismatches;
      pending_o <= expected_tokens.size();
    end
  end

endmodule

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the command line tokenizer.
// A few hand-made lines hit the corner cases, then random lines follow:
// mostly well-formed commands with bare, quoted and dash-key values, plus
// truncated, mutated and noise lines. Both sides idle in random bursts; the
// receiver holds off once for a long stretch, and the sender drains once.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int WatchdogLimit = 2000;
  localparam int RandomItems   = 1200;
  localparam int CalmItems     = 1000;
  localparam int LongHold      = 80;

  localparam logic [7:0] DirectedBytes [26] = '{
    8'h00,
    8'hFF, 8'h00,
    " ", "x", 8'h00,
    " ", "-", "a", " ", "\"", "\\", "x", "\"", 8'h00,
    " ", "-", "a", " ", "1", " ", "-", "a", " ", "2", 8'h00
  };

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  dctok_in_if  in_if ();
  dctok_out_if out_if ();

  int  fail_count;
  int  pending_count;
  int  items_sent;
  int  stuck_cycles = 0;
  bit  idle_on = 1'b1;
  bit  long_hold_req = 1'b0;
  logic [7:0] line_buf [$];

  debug_command_line_tokenizer_unit i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  dctok_token_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_if),
    .tok_i        (out_if),
    .fail_count_o (fail_count),
    .pending_o    (pending_count)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni && !((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))) begin
      stuck_cycles++;
    end else begin
      stuck_cycles = 0;
    end
    if (stuck_cycles >= WatchdogLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  // token receiver
  initial begin
    bit hold_taken;
    hold_taken = 1'b0;
    forever begin
      if (long_hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        out_if.ready <= 1'b0;
        repeat (LongHold) @(posedge clk_i);
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
      end else begin
        out_if.ready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    if (idle_on && $urandom_range(0, 7) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.in_byte <= b;
    do @(posedge clk_i); while (!in_if.ready);
    items_sent++;
  endtask

  task automatic send_line();
    foreach (line_buf[i]) send_byte(line_buf[i]);
  endtask

  task automatic wait_drained();
    repeat (2) @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
  endtask

  function automatic logic [7:0] word_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(1, 255)); while (b == " ");
    return b;
  endfunction

  function automatic void add_escape();
    string hex_chars = "0123456789abcdefABCDEF";
    string ctl_chars = "ntravbf";
    int    n;
    line_buf.push_back("\\");
    case ($urandom_range(0, 4))
      0: line_buf.push_back(ctl_chars[$urandom_range(0, 6)]);
      1: begin
        line_buf.push_back("x");
        n = $urandom_range(0, 2);
        repeat (n) line_buf.push_back(hex_chars[$urandom_range(0, 21)]);
      end
      2: begin
        n = $urandom_range(1, 3);
        repeat (n) line_buf.push_back(8'("0" + $urandom_range(0, 7)));
      end
      default: line_buf.push_back(8'($urandom_range(1, 255)));
    endcase
  endfunction

  function automatic void compose_good();
    int         n_cmd;
    int         n_opt;
    int         n;
    logic [7:0] key;
    logic [7:0] b;
    line_buf.delete();
    n_cmd = $urandom_range(0, 5);
    repeat (n_cmd) line_buf.push_back(word_byte());
    n_opt = $urandom_range(0, 3);
    if (n_opt > 0) line_buf.push_back(" ");
    for (int i = 0; i < n_opt; i++) begin
      if (i > 0) line_buf.push_back(" ");
      line_buf.push_back("-");
      case ($urandom_range(0, 5))
        0: key = 8'($urandom_range(1, 255));
        1: key = "-";
        default: key = 8'("a" + $urandom_range(0, 2));
      endcase
      line_buf.push_back(key);
      line_buf.push_back(" ");
      if (key == "-") begin
        n = $urandom_range(0, 6);
        repeat (n) line_buf.push_back(8'($urandom_range(1, 255)));
        break;
      end else if ($urandom_range(0, 1) == 1) begin
        line_buf.push_back("\"");
        n = $urandom_range(0, 5);
        repeat (n) begin
          if ($urandom_range(0, 2) == 0) begin
            add_escape();
          end else begin
            do b = 8'($urandom_range(1, 255)); while (b == "\\" || b == "\"");
            line_buf.push_back(b);
          end
        end
        line_buf.push_back("\"");
      end else begin
        do b = word_byte(); while (b == "\"");
        line_buf.push_back(b);
        n = $urandom_range(0, 3);
        repeat (n) line_buf.push_back(word_byte());
      end
    end
    line_buf.push_back(8'h00);
  endfunction

  function automatic void compose_line();
    int sel;
    int keep;
    sel = $urandom_range(0, 9);
    if (sel == 8) begin
      line_buf.delete();
      repeat ($urandom_range(1, 8)) begin
        case ($urandom_range(0, 4))
          0: line_buf.push_back("-");
          1: line_buf.push_back(" ");
          2: line_buf.push_back(($urandom_range(0, 1) == 1) ? 8'h22 : 8'h5C);
          default: line_buf.push_back(8'($urandom_range(0, 255)));
        endcase
      end
      line_buf.push_back(8'h00);
      return;
    end
    compose_good();
    if (sel == 7) begin
      keep = $urandom_range(0, line_buf.size() - 1);
      while (line_buf.size() > keep) line_buf.delete(line_buf.size() - 1);
      line_buf.push_back(8'h00);
    end else if (sel == 9 && line_buf.size() > 1) begin
      line_buf[$urandom_range(0, line_buf.size() - 2)] = 8'($urandom_range(0, 255));
    end
  endfunction

  initial begin
    bit hold_done;
    bit drain_done;
    hold_done     = 1'b0;
    drain_done    = 1'b0;
    in_if.valid   = 1'b0;
    in_if.in_byte = 8'h00;
    items_sent    = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    line_buf.delete();
    foreach (DirectedBytes[i]) line_buf.push_back(DirectedBytes[i]);
    send_line();

    items_sent = 0;
    while (items_sent < RandomItems) begin
      if (items_sent >= CalmItems) idle_on = 1'b0;
      if (!hold_done && items_sent > 300) begin
        long_hold_req = 1'b1;
        hold_done = 1'b1;
      end
      if (!drain_done && items_sent > 700) begin
        in_if.valid <= 1'b0;
        wait_drained();
        drain_done = 1'b1;
      end
      compose_line();
      send_line();
    end
    in_if.valid <= 1'b0;

    wait_drained();
    repeat (10) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
